// ===== src/scpl_pkg.sv =====
// Shared types and constants for the stereo capture ping-pong looper.
// No dependencies; the core, scpl_ctrl and the testbench import this package.
package scpl_pkg;

    // Sideband bits of the input word, lowest bit first.
    localparam int TUSER_W     = 2;
    localparam int CAPTURE_BIT = 0;
    localparam int CLEAR_BIT   = 1;

    // Frame memory operation for the word now in the work stage.
    typedef struct packed {
        logic wr;   // store the incoming frame
        logic rd;   // fetch a loop frame, which becomes a result word
    } mem_op_t;

endpackage

// ===== src/stereo_capture_pingpong_looper_core.sv =====
// Top level of the stereo capture looper with ping-pong playback.
// Depends on scpl_pkg, scpl_ctrl and scpl_ram.
//
//  Channel  Direction  Payload                                      Handshake
//  s_*      in         tdata: left_in, right_in; tuser: capture,    tvalid/tready
//                      clear
//  m_*      out        tdata: left_out, right_out                   tvalid/tready
//
// The block takes one word per cycle on the input side unless a word that
// would produce a result is held back by a stalled output. A word is held in
// an input register, where the loop state is updated and the single frame
// memory port either stores the frame or fetches a loop frame; a fetched
// frame is presented on the output from the memory read register. Reset
// clears the recording flag, count and play position; the frame memory needs
// no clearing pass. A stalled output only holds back words that would produce
// a result, so recording words keep flowing meanwhile.
module stereo_capture_pingpong_looper_core #(
    parameter int MAX_FRAMES  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // s_tdata: left_in, right_in, zero fill to whole bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
    // s_tuser: capture, clear
    input  logic [scpl_pkg::TUSER_W-1:0]               s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // m_tdata: left_out, right_out, zero fill to whole bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_tdata
);
    import scpl_pkg::*;

    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAME_W = 2 * SAMPLE_BITS;
    localparam int ADDR_W  = $clog2(MAX_FRAMES);

    // Input register.
    logic               in_valid_reg;
    logic               in_capture_reg;
    logic               in_clear_reg;
    logic [FRAME_W-1:0] in_frame_reg;

    // Result register flag; the frame itself sits in the memory read register.
    logic               out_valid_reg;
    logic               out_valid_next;

    mem_op_t            op;
    logic [ADDR_W-1:0]  addr;
    logic               out_free;
    logic               go;
    logic               mem_we;
    logic               mem_re;
    logic [FRAME_W-1:0] rd_frame;

    // The held word may proceed unless it makes a result and the output is full.
    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && (!op.rd || out_free);
    assign s_tready = !in_valid_reg || go;
    assign mem_we   = go && op.wr;
    assign mem_re   = go && op.rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_capture_reg <= s_tuser[CAPTURE_BIT];
            in_clear_reg   <= s_tuser[CLEAR_BIT];
            in_frame_reg   <= s_tdata[FRAME_W-1:0];
        end
    end

    scpl_ctrl #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .capture (in_capture_reg),
        .clear   (in_clear_reg),
        .op      (op),
        .addr    (addr)
    );

    scpl_ram #(
        .DEPTH  (MAX_FRAMES),
        .DATA_W (FRAME_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (addr),
        .wdata (in_frame_reg),
        .rdata (rd_frame)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mem_re)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(rd_frame);

`ifndef SYNTH
    // The single memory port never stores and fetches in the same cycle.
    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("frame memory written and read in one cycle");

    // A fetch never overwrites a result word that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (!out_valid_reg || m_tready))
        else $error("result word overwritten while stalled");

    // Recording words never produce a result.
    a_capture_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_capture_reg) |-> !op.rd)
        else $error("capture word produced a fetch");
`endif

endmodule

// ===== src/scpl_ctrl.sv =====
// Loop state and frame memory addressing for the looper.
// Depends on scpl_pkg for the memory operation struct.
module scpl_ctrl #(
    parameter int MAX_FRAMES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic                            capture,
    input  logic                            clear,
    output scpl_pkg::mem_op_t               op,
    output logic [$clog2(MAX_FRAMES)-1:0]   addr
);
    import scpl_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_FRAMES);
    localparam int COUNT_W = $clog2(MAX_FRAMES + 1);
    localparam int LEN_W   = COUNT_W + 1;
    localparam int POS_W   = $clog2(2 * MAX_FRAMES);

    logic               rec_reg;
    logic               rec_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic [COUNT_W-1:0] count_eff;
    logic [LEN_W-1:0]   loop_len;
    logic [LEN_W-1:0]   pos_inc;
    logic [LEN_W-1:0]   pos_wrap;
    logic [LEN_W-1:0]   mirror;

    always_comb
    begin
        rec_next   = rec_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        op         = '0;
        addr       = '0;

        count_eff  = clear ? '0 : count_reg;
        loop_len   = {count_eff, 1'b0};
        pos_inc    = '0;
        pos_wrap   = '0;
        mirror     = '0;

        if (capture)
        begin
            // A fresh recording starts from an empty memory.
            if (!rec_reg)
            begin
                count_eff = '0;
            end
            rec_next = 1'b1;
            addr     = count_eff[ADDR_W-1:0];
            if (count_eff < COUNT_W'(MAX_FRAMES))
            begin
                op.wr      = 1'b1;
                count_next = count_eff + COUNT_W'(1);
            end
            else
            begin
                count_next = count_eff;
            end
        end
        else
        begin
            rec_next   = 1'b0;
            count_next = count_eff;
            if (rec_reg)
            begin
                pos_next = '0;
            end
            if (count_eff != '0)
            begin
                pos_inc  = (rec_reg ? '0 : LEN_W'(pos_reg)) + LEN_W'(1);
                pos_wrap = (pos_inc >= loop_len) ? '0 : pos_inc;
                pos_next = pos_wrap[POS_W-1:0];
                // The second half of the loop plays the recording backwards.
                mirror   = loop_len - LEN_W'(1) - pos_wrap;
                if (pos_wrap < LEN_W'(count_eff))
                begin
                    addr = pos_wrap[ADDR_W-1:0];
                end
                else
                begin
                    addr = mirror[ADDR_W-1:0];
                end
                op.rd = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg   <= 1'b0;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else if (go)
        begin
            rec_reg   <= rec_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== src/scpl_ram.sv =====
// Single-port frame memory with a registered read port.
// No package dependencies.
module scpl_ram #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking regression bench for stereo_capture_pingpong_looper_core.
// Depends on scpl_pkg and the core RTL; it carries its own loop predictor and
// compares every output word against it.
module testbench;

    import scpl_pkg::*;

    localparam int MAX_FRAMES  = 65536;
    localparam int SAMPLE_BITS = 24;
    localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int STORE_AW    = $clog2(MAX_FRAMES);
    localparam int MAX_REPORTS = 10;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN  = 24'h800000;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ZERO = 24'h000000;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = 24'hFFFFFF;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // s_tdata: left_in, right_in
    logic [DATA_W-1:0]   s_tdata;
    // s_tuser: capture, clear
    logic [TUSER_W-1:0]  s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // m_tdata: left_out, right_out
    logic [DATA_W-1:0]   m_tdata;

    stereo_capture_pingpong_looper_core #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor state: a private copy of the looper's recording flag, frame
    // count, play position and frame store. A stored frame keeps the left
    // sample in the low half, the same layout as the data bus.
    logic                         recording;
    logic [16:0]                  captured_frames;
    logic [17:0]                  play_index;
    logic [2*SAMPLE_BITS-1:0]     loop_store [0:MAX_FRAMES-1];

    // Frames the core still owes us, oldest first.
    logic [2*SAMPLE_BITS-1:0]     pending_frames [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles_left;
    int mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous watchdog, far beyond the slowest legal run.
    initial
    begin
        #(20 * 1000000);
        $display("stereo_capture_pingpong_looper_core regression: fail");
        $finish;
    end

    // Updates the predictor with one accepted word and queues the frame that
    // the core must play back for it, if any.
    task automatic predict_loop_frame(input bit capture, input bit clear,
                                      input logic [2*SAMPLE_BITS-1:0] frame);
        int span;
        int pos;
        int idx;
        if (clear)
            captured_frames = '0;
        if (capture)
        begin
            // A fresh recording always starts from an empty store.
            if (!recording)
            begin
                captured_frames = '0;
                recording = 1'b1;
            end
            // Once the store is full, further captured frames are dropped.
            if (captured_frames < MAX_FRAMES)
            begin
                loop_store[captured_frames[STORE_AW-1:0]] = frame;
                captured_frames = captured_frames + 1'b1;
            end
        end
        else
        begin
            // The falling edge of capture rewinds the loop.
            if (recording)
            begin
                play_index = '0;
                recording = 1'b0;
            end
            // An empty loop plays nothing and leaves the position alone.
            if (captured_frames != 0)
            begin
                span = 2 * int'(captured_frames);
                pos  = int'(play_index) + 1;
                if (pos >= span)
                    pos = 0;
                play_index = pos[17:0];
                // The second half of the loop walks the recording backwards.
                idx = pos;
                if (idx >= int'(captured_frames))
                    idx = span - 1 - idx;
                pending_frames.insert(pending_frames.size(),
                                      loop_store[idx[STORE_AW-1:0]]);
            end
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_ZERO;
            3:       return SAMPLE_NEG1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Offers one word and holds it until the core takes it. Called and left
    // at a falling edge; tvalid stays high on exit so back-to-back words need
    // no extra edge on it.
    task automatic send_word(input bit capture, input bit clear,
                             input logic [SAMPLE_BITS-1:0] left,
                             input logic [SAMPLE_BITS-1:0] right);
        logic [TUSER_W-1:0] user;
        user              = '0;
        user[CAPTURE_BIT] = capture;
        user[CLEAR_BIT]   = clear;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= user;
        do
            @(posedge clk);
        while (!s_tready);
        predict_loop_frame(capture, clear, {right, left});
        @(negedge clk);
    endtask

    // Output side: random stalls, or a long counted hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles_left > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles_left = hold_cycles_left - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Output checker: every word taken from the core must match the oldest
    // outstanding prediction, channel by channel.
    initial
    begin
        logic [2*SAMPLE_BITS-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_frames.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected output word %h", m_tdata);
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== want[SAMPLE_BITS-1:0])
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("left_out: expected %h, got %h",
                                     want[SAMPLE_BITS-1:0],
                                     m_tdata[SAMPLE_BITS-1:0]);
                    end
                    if (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !==
                        want[2*SAMPLE_BITS-1:SAMPLE_BITS])
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("right_out: expected %h, got %h",
                                     want[2*SAMPLE_BITS-1:SAMPLE_BITS],
                                     m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                    end
                end
            end
        end
    end

    // Hand-picked words: playing an empty loop, sample extremes, a full
    // ping-pong pass with wrap, clearing while recording, clearing during
    // playback and clearing on the word that ends a recording.
    task automatic test_directed();
        send_word(1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_word(1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MAX);

        send_word(1'b1, 1'b0, SAMPLE_MIN, SAMPLE_MAX);
        send_word(1'b1, 1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_word(1'b1, 1'b0, SAMPLE_ZERO, SAMPLE_NEG1);
        send_word(1'b1, 1'b0, SAMPLE_NEG1, SAMPLE_ZERO);
        // Nine playback words cover both halves and the wrap to the start.
        for (int k = 0; k < 9; k++)
            send_word(1'b0, 1'b0, pick_sample(), pick_sample());

        send_word(1'b1, 1'b0, 24'h123456, 24'h654321);
        send_word(1'b1, 1'b1, 24'hABCDEF, 24'hFEDCBA);
        send_word(1'b1, 1'b0, 24'h55AA55, 24'hAA55AA);
        send_word(1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO);
        send_word(1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO);
        send_word(1'b0, 1'b1, SAMPLE_NEG1, SAMPLE_NEG1);
        send_word(1'b0, 1'b0, SAMPLE_NEG1, SAMPLE_NEG1);

        send_word(1'b1, 1'b0, 24'h0F0F0F, 24'hF0F0F0);
        send_word(1'b0, 1'b1, SAMPLE_MAX, SAMPLE_MAX);
        send_word(1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MIN);
    endtask

    // Mostly well-formed sessions, a burst of capture words followed by a
    // burst of playback, with sparse clears; the rest is random noise.
    task automatic test_random_sessions(input int word_budget);
        int sent;
        int take_len;
        int play_len;
        sent = 0;
        while (sent < word_budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                play_len = $urandom_range(1, 4);
                for (int k = 0; k < play_len; k++)
                    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              pick_sample(), pick_sample());
                sent = sent + play_len;
            end
            else
            begin
                take_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                for (int k = 0; k < take_len; k++)
                    send_word(1'b1, $urandom_range(0, 99) < 4,
                              pick_sample(), pick_sample());
                play_len = $urandom_range(1, 3 * take_len + 2);
                for (int k = 0; k < play_len; k++)
                    send_word(1'b0, $urandom_range(0, 99) < 3,
                              pick_sample(), pick_sample());
                sent = sent + take_len + play_len;
            end
        end
    endtask

    // The output side stops for a long stretch while playback words keep
    // coming, so the core's pipeline fills and it must hold off its input.
    task automatic test_output_backpressure();
        hold_cycles_left = 300;
        for (int k = 0; k < 6; k++)
            send_word(1'b1, 1'b0, pick_sample(), pick_sample());
        for (int k = 0; k < 80; k++)
            send_word(1'b0, 1'b0, pick_sample(), pick_sample());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = '0;
        m_tready         = 1'b0;
        send_idle_pct    = 28;
        recv_stall_pct   = 61;
        hold_cycles_left = 0;
        mismatch_count   = 0;
        recording        = 1'b0;
        captured_frames  = '0;
        play_index       = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // First the input side idles less than the output side stalls.
        test_directed();
        test_random_sessions(180);

        // Then the other way round.
        send_idle_pct  = 61;
        recv_stall_pct = 28;
        test_random_sessions(180);
        test_output_backpressure();

        // Finally neither side idles.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_sessions(180);

        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        // Let any stray word surface before deciding.
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("stereo_capture_pingpong_looper_core regression: pass");
        else
            $display("stereo_capture_pingpong_looper_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/scpl_pkg.sv
src/scpl_ctrl.sv
src/scpl_ram.sv
src/stereo_capture_pingpong_looper_core.sv
dv/testbench.sv
